// ----- sv/i2cjs_pkg.sv -----
// shared constants, codes and record types of the i2c job sequencer
`timescale 1ns / 1ps
`default_nettype none
package i2cjs_pkg;

    localparam int TASK_DEPTH = 16;
    localparam int BYTE_DEPTH = 64;
    localparam int TASK_AW    = $clog2(TASK_DEPTH);
    localparam int TASK_CW    = $clog2(TASK_DEPTH + 1);
    localparam int BYTE_AW    = $clog2(BYTE_DEPTH);
    localparam int BYTE_CW    = $clog2(BYTE_DEPTH + 1);

    // commands
    localparam logic [2:0] CMD_BEGIN = 3'd0;
    localparam logic [2:0] CMD_ADD   = 3'd1;
    localparam logic [2:0] CMD_STAGE = 3'd2;
    localparam logic [2:0] CMD_FINAL = 3'd3;
    localparam logic [2:0] CMD_EVENT = 3'd4;
    localparam logic [2:0] CMD_ERROR = 3'd5;

    // task kinds
    localparam logic [2:0] KIND_START = 3'd0;
    localparam logic [2:0] KIND_WMODE = 3'd1;
    localparam logic [2:0] KIND_RMODE = 3'd2;
    localparam logic [2:0] KIND_WRITE = 3'd3;
    localparam logic [2:0] KIND_READ  = 3'd4;
    localparam logic [2:0] KIND_STOP  = 3'd5;

    // bus actions
    localparam logic [2:0] ACT_NONE  = 3'd0;
    localparam logic [2:0] ACT_START = 3'd1;
    localparam logic [2:0] ACT_ADDRW = 3'd2;
    localparam logic [2:0] ACT_ADDRR = 3'd3;
    localparam logic [2:0] ACT_SEND  = 3'd4;
    localparam logic [2:0] ACT_READ  = 3'd5;
    localparam logic [2:0] ACT_STOP  = 3'd6;

    typedef struct packed {
        logic [2:0]  kind;
        logic [6:0]  addr;
        logic [15:0] len;
        logic [31:0] ref_val;   // read: buffer address, write: byte ring start
    } task_rec_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [6:0]  addr;
        logic [7:0]  data;
        logic [15:0] len;
        logic [31:0] buffer;
        logic        result;
    } res_t;

endpackage
`default_nettype wire

// ----- sv/i2c_master_job_sequencer_unit.sv -----
// top level of the i2c master job sequencer: task ring, byte ring and bus sequencer
`timescale 1ns / 1ps
`default_nettype none
//
// channel  | dir | tdata / tuser fields (low bit up)                        | end of item
// s_*      | in  | tuser: command; tdata: task_kind, device_address,        | s_tvalid & s_tready
//          |     |   transfer_length, data_byte, buffer_address            |
// m_*      | out | tdata: accepted, action, out_address, out_byte,          | m_tvalid & m_tready
//          |     |   out_length, out_buffer, job_result; tlast: last        |
//
// one transaction at a time: the accept, then each result in turn on m_*, held until taken
// a bus event runs the task through ST_RUN_W (memory read at the ring tail) and ST_RUN,
// and steps to the next task through ST_ENT_W and ST_ENT when it completes; a start after a stop then runs too
// a committing finalize, when not busy, enters the first task through ST_ENT_W and ST_ENT before it runs
// a bus error passes through ST_ENT_W and ST_ENT for each task flushed
// reset clears all pointers, counts and flags; the rings themselves are not cleared
// results wait in a two-slot buffer until taken, input is held off until then
//
module i2c_master_job_sequencer_unit
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,   // task_kind, device_address, transfer_length, data_byte, buffer_address
    input  wire logic [2:0]  s_tuser,   // command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0] m_tdata,        // accepted, action, out_address, out_byte, out_length, out_buffer, job_result
    output logic        m_tlast         // last
);

    localparam int TAW = i2cjs_pkg::TASK_AW;
    localparam int TCW = i2cjs_pkg::TASK_CW;
    localparam int BAW = i2cjs_pkg::BYTE_AW;
    localparam int BCW = i2cjs_pkg::BYTE_CW;

    // sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_ENT_W = 4'd1;
    localparam logic [3:0] ST_ENT   = 4'd2;
    localparam logic [3:0] ST_RUN_W = 4'd3;
    localparam logic [3:0] ST_RUN   = 4'd4;
    localparam logic [3:0] ST_OUT   = 4'd5;

    // where to go after the task entry step
    localparam logic [1:0] RET_RUN   = 2'd0;
    localparam logic [1:0] RET_POST  = 2'd1;
    localparam logic [1:0] RET_FLUSH = 2'd2;

    // input fields
    logic [2:0]  in_cmd;
    logic [2:0]  in_kind;
    logic [6:0]  in_addr;
    logic [15:0] in_len;
    logic [7:0]  in_byte;
    logic [31:0] in_buf;

    assign in_cmd  = s_tuser;
    assign in_kind = s_tdata[2:0];
    assign in_addr = s_tdata[9:3];
    assign in_len  = s_tdata[25:10];
    assign in_byte = s_tdata[33:26];
    assign in_buf  = s_tdata[65:34];

    // ring memories, read every cycle at the tail
    i2cjs_pkg::task_rec_t task_mem [i2cjs_pkg::TASK_DEPTH];
    logic [7:0]           byte_mem [i2cjs_pkg::BYTE_DEPTH];
    i2cjs_pkg::task_rec_t task_q_reg;
    logic [7:0]           byte_q0_reg, byte_q1_reg;

    logic                 task_we;
    logic [TAW-1:0]       task_waddr;
    i2cjs_pkg::task_rec_t task_wdata;
    logic                 byte_we;
    logic [BAW-1:0]       byte_waddr;

    // control state
    logic [3:0]     state_reg, state_next;
    logic [1:0]     ret_reg, ret_next;
    logic [TAW-1:0] task_head_reg, task_head_next, task_tail_reg, task_tail_next;
    logic [TCW-1:0] task_count_reg, task_count_next, task_staged_reg, task_staged_next;
    logic [BAW-1:0] byte_head_reg, byte_head_next, byte_tail_reg, byte_tail_next;
    logic [BCW-1:0] byte_count_reg, byte_count_next, byte_staged_reg, byte_staged_next;
    logic           job_open_reg, job_open_next, job_ok_reg, job_ok_next;
    logic           busy_reg, busy_next, status_reg, status_next;
    logic           was_stop_reg, was_stop_next, acc_reg, acc_next;
    logic [15:0]    sent_reg, sent_next;
    logic [1:0]     res_n_reg, res_n_next;
    logic           out_idx_reg, out_idx_next;
    i2cjs_pkg::res_t res_reg [2];
    i2cjs_pkg::res_t res_next [2];

    // results raised this cycle
    logic [1:0]      e_cnt;
    i2cjs_pkg::res_t e0, e1;

    // helpers
    logic [TCW:0]   task_fill;
    logic [BCW:0]   byte_fill;
    logic [BAW-1:0] ent_idx, ent_d;
    logic [16:0]    bs1, bs2;
    logic           two, complete, out_last;
    logic [1:0]     taken;
    logic [BCW-1:0] taken_w;
    logic [BCW-1:0] commit_bytes;
    logic [TCW-1:0] commit_tasks;
    logic [1:0]     n_eff;

    always_comb
    begin
        state_next       = state_reg;
        ret_next         = ret_reg;
        task_head_next   = task_head_reg;
        task_tail_next   = task_tail_reg;
        task_count_next  = task_count_reg;
        task_staged_next = task_staged_reg;
        byte_head_next   = byte_head_reg;
        byte_tail_next   = byte_tail_reg;
        byte_count_next  = byte_count_reg;
        byte_staged_next = byte_staged_reg;
        job_open_next    = job_open_reg;
        job_ok_next      = job_ok_reg;
        busy_next        = busy_reg;
        status_next      = status_reg;
        was_stop_next    = was_stop_reg;
        acc_next         = acc_reg;
        sent_next        = sent_reg;
        res_n_next       = res_n_reg;
        out_idx_next     = out_idx_reg;
        res_next[0]      = res_reg[0];
        res_next[1]      = res_reg[1];
        e_cnt            = 2'd0;
        e0               = '0;
        e1               = '0;
        task_we          = 1'b0;
        task_waddr       = TAW'(task_head_reg + TAW'(task_staged_reg));
        task_wdata.kind    = in_kind;
        task_wdata.addr    = in_addr;
        task_wdata.len     = in_len;
        task_wdata.ref_val = (in_kind == i2cjs_pkg::KIND_WRITE)
                           ? {{(32 - BAW){1'b0}}, BAW'(byte_head_reg + BAW'(byte_staged_reg))}
                           : in_buf;
        byte_we          = 1'b0;
        byte_waddr       = BAW'(byte_head_reg + BAW'(byte_staged_reg));
        task_fill        = {1'b0, task_count_reg} + {1'b0, task_staged_reg};
        byte_fill        = {1'b0, byte_count_reg} + {1'b0, byte_staged_reg} + (BCW + 1)'(1);
        commit_tasks     = task_count_reg + task_staged_reg;
        commit_bytes     = byte_count_reg + byte_staged_reg;
        ent_idx          = task_q_reg.ref_val[BAW-1:0];
        ent_d            = ent_idx - byte_tail_reg;
        bs1              = {1'b0, sent_reg} + 17'd1;
        bs2              = bs1 + 17'd1;
        two              = bs1 < {1'b0, task_q_reg.len};
        complete         = 1'b1;
        taken            = 2'd0;
        taken_w          = '0;
        n_eff            = (res_n_reg == 2'd0) ? 2'd1 : res_n_reg;
        out_last         = ({1'b0, out_idx_reg} + 2'd1) == n_eff;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    acc_next     = 1'b0;
                    res_n_next   = 2'd0;
                    out_idx_next = 1'b0;
                    res_next[0]  = '0;
                    state_next   = ST_OUT;
                    unique case (in_cmd)
                        i2cjs_pkg::CMD_BEGIN:
                        begin
                            if (!job_open_reg)
                            begin
                                job_open_next = 1'b1;
                                job_ok_next   = 1'b1;
                                acc_next      = 1'b1;
                            end
                        end
                        i2cjs_pkg::CMD_ADD:
                        begin
                            if (job_open_reg && in_kind <= i2cjs_pkg::KIND_STOP)
                            begin
                                if (task_fill >= (TCW + 1)'(i2cjs_pkg::TASK_DEPTH))
                                    job_ok_next = 1'b0;
                                else
                                begin
                                    task_we          = 1'b1;
                                    task_staged_next = task_staged_reg + TCW'(1);
                                    acc_next         = 1'b1;
                                end
                            end
                        end
                        i2cjs_pkg::CMD_STAGE:
                        begin
                            if (job_open_reg)
                            begin
                                if (byte_fill >= (BCW + 1)'(i2cjs_pkg::BYTE_DEPTH))
                                    job_ok_next = 1'b0;
                                else
                                begin
                                    byte_we          = 1'b1;
                                    byte_staged_next = byte_staged_reg + BCW'(1);
                                    acc_next         = 1'b1;
                                end
                            end
                        end
                        i2cjs_pkg::CMD_FINAL:
                        begin
                            if (job_open_reg)
                            begin
                                job_open_next    = 1'b0;
                                task_staged_next = '0;
                                byte_staged_next = '0;
                                if (job_ok_reg)
                                begin
                                    task_head_next  = TAW'(task_head_reg + TAW'(task_staged_reg));
                                    task_count_next = commit_tasks;
                                    byte_head_next  = BAW'(byte_head_reg + BAW'(byte_staged_reg));
                                    byte_count_next = commit_bytes;
                                    status_next     = 1'b0;
                                    acc_next        = 1'b1;
                                    if (!busy_reg && commit_tasks != '0)
                                    begin
                                        ret_next   = RET_RUN;
                                        state_next = ST_ENT_W;
                                    end
                                end
                            end
                        end
                        i2cjs_pkg::CMD_EVENT:
                        begin
                            if (busy_reg && task_count_reg != '0)
                            begin
                                acc_next   = 1'b1;
                                state_next = ST_RUN_W;
                            end
                        end
                        i2cjs_pkg::CMD_ERROR:
                        begin
                            acc_next    = 1'b1;
                            status_next = 1'b1;
                            if (busy_reg)
                            begin
                                // skip the current task, then flush up to a stop
                                if (task_count_reg != '0)
                                begin
                                    task_tail_next  = task_tail_reg + TAW'(1);
                                    task_count_next = task_count_reg - TCW'(1);
                                end
                                ret_next   = RET_FLUSH;
                                state_next = ST_ENT_W;
                            end
                            else if (task_count_reg != '0)
                                state_next = ST_RUN_W;
                            else
                            begin
                                e_cnt         = 2'd1;
                                e0.action     = i2cjs_pkg::ACT_STOP;
                                e0.result     = 1'b1;
                                busy_next     = 1'b0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_ENT_W:
                state_next = ST_ENT;
            ST_ENT:
            begin
                // write task entry: drop bytes up to the task's start
                if (task_count_reg != '0 && task_q_reg.kind == i2cjs_pkg::KIND_WRITE)
                begin
                    if ({{(BCW - BAW){1'b0}}, ent_d} <= byte_count_reg)
                    begin
                        byte_tail_next  = ent_idx;
                        byte_count_next = byte_count_reg - {{(BCW - BAW){1'b0}}, ent_d};
                    end
                    else
                    begin
                        byte_tail_next  = byte_head_reg;
                        byte_count_next = '0;
                    end
                    sent_next = '0;
                end
                unique case (ret_reg)
                    RET_RUN:
                        state_next = ST_RUN_W;
                    RET_POST:
                    begin
                        busy_next = task_count_reg != '0;
                        if (task_count_reg != '0 && was_stop_reg
                            && task_q_reg.kind == i2cjs_pkg::KIND_START)
                            state_next = ST_RUN_W;
                        else
                            state_next = ST_OUT;
                    end
                    RET_FLUSH:
                    begin
                        if (task_count_reg != '0 && task_q_reg.kind != i2cjs_pkg::KIND_STOP)
                        begin
                            task_tail_next  = task_tail_reg + TAW'(1);
                            task_count_next = task_count_reg - TCW'(1);
                            state_next      = ST_ENT_W;
                        end
                        else if (task_count_reg != '0)
                            state_next = ST_RUN_W;
                        else
                        begin
                            e_cnt      = 2'd1;
                            e0.action  = i2cjs_pkg::ACT_STOP;
                            e0.result  = 1'b1;
                            busy_next  = 1'b0;
                            state_next = ST_OUT;
                        end
                    end
                    default:
                        state_next = ST_OUT;
                endcase
            end
            ST_RUN_W:
                state_next = ST_RUN;
            ST_RUN:
            begin
                busy_next     = 1'b1;
                was_stop_next = 1'b0;
                e_cnt         = 2'd1;
                unique case (task_q_reg.kind)
                    i2cjs_pkg::KIND_START:
                        e0.action = i2cjs_pkg::ACT_START;
                    i2cjs_pkg::KIND_WMODE:
                    begin
                        e0.action = i2cjs_pkg::ACT_ADDRW;
                        e0.addr   = task_q_reg.addr;
                    end
                    i2cjs_pkg::KIND_RMODE:
                    begin
                        e0.action = i2cjs_pkg::ACT_ADDRR;
                        e0.addr   = task_q_reg.addr;
                    end
                    i2cjs_pkg::KIND_WRITE:
                    begin
                        e0.action = i2cjs_pkg::ACT_SEND;
                        e0.data   = (byte_count_reg != '0) ? byte_q0_reg : 8'd0;
                        e1.action = i2cjs_pkg::ACT_SEND;
                        e1.data   = (byte_count_reg > BCW'(1)) ? byte_q1_reg : 8'd0;
                        if (two)
                        begin
                            e_cnt     = 2'd2;
                            sent_next = bs2[15:0];
                            complete  = bs2 >= {1'b0, task_q_reg.len};
                            taken     = 2'd2;
                        end
                        else
                        begin
                            sent_next = bs1[15:0];
                            complete  = 1'b1;
                            taken     = 2'd1;
                        end
                        // the ring hands out no more bytes than it holds
                        if (byte_count_reg < BCW'(taken))
                            taken_w = byte_count_reg;
                        else
                            taken_w = BCW'(taken);
                        byte_tail_next  = byte_tail_reg + BAW'(taken_w);
                        byte_count_next = byte_count_reg - taken_w;
                    end
                    i2cjs_pkg::KIND_READ:
                    begin
                        e0.action = i2cjs_pkg::ACT_READ;
                        e0.len    = task_q_reg.len;
                        e0.buffer = task_q_reg.ref_val;
                    end
                    default:
                    begin
                        e0.action     = i2cjs_pkg::ACT_STOP;
                        e0.result     = status_reg;
                        was_stop_next = 1'b1;
                    end
                endcase
                if (complete)
                begin
                    if (task_count_reg != '0)
                    begin
                        task_tail_next  = task_tail_reg + TAW'(1);
                        task_count_next = task_count_reg - TCW'(1);
                    end
                    ret_next   = RET_POST;
                    state_next = ST_ENT_W;
                end
                else
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (m_tready)
                begin
                    if (out_last)
                        state_next = ST_IDLE;
                    else
                        out_idx_next = 1'b1;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase

        // place new results in the two-slot buffer, after any clear at accept
        if (e_cnt != 2'd0)
        begin
            if (res_n_next == 2'd0)
            begin
                res_next[0] = e0;
                if (e_cnt == 2'd2)
                    res_next[1] = e1;
                res_n_next = e_cnt;
            end
            else if (res_n_next == 2'd1)
            begin
                res_next[1] = e0;
                res_n_next  = 2'd2;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (task_we)
            task_mem[task_waddr] <= task_wdata;
        if (byte_we)
            byte_mem[byte_waddr] <= in_byte;
        task_q_reg  <= task_mem[task_tail_reg];
        byte_q0_reg <= byte_mem[byte_tail_reg];
        byte_q1_reg <= byte_mem[byte_tail_reg + BAW'(1)];
        res_reg[0]  <= res_next[0];
        res_reg[1]  <= res_next[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            ret_reg         <= RET_RUN;
            task_head_reg   <= '0;
            task_tail_reg   <= '0;
            task_count_reg  <= '0;
            task_staged_reg <= '0;
            byte_head_reg   <= '0;
            byte_tail_reg   <= '0;
            byte_count_reg  <= '0;
            byte_staged_reg <= '0;
            job_open_reg    <= 1'b0;
            job_ok_reg      <= 1'b0;
            busy_reg        <= 1'b0;
            status_reg      <= 1'b0;
            was_stop_reg    <= 1'b0;
            acc_reg         <= 1'b0;
            sent_reg        <= '0;
            res_n_reg       <= '0;
            out_idx_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            ret_reg         <= ret_next;
            task_head_reg   <= task_head_next;
            task_tail_reg   <= task_tail_next;
            task_count_reg  <= task_count_next;
            task_staged_reg <= task_staged_next;
            byte_head_reg   <= byte_head_next;
            byte_tail_reg   <= byte_tail_next;
            byte_count_reg  <= byte_count_next;
            byte_staged_reg <= byte_staged_next;
            job_open_reg    <= job_open_next;
            job_ok_reg      <= job_ok_next;
            busy_reg        <= busy_next;
            status_reg      <= status_next;
            was_stop_reg    <= was_stop_next;
            acc_reg         <= acc_next;
            sent_reg        <= sent_next;
            res_n_reg       <= res_n_next;
            out_idx_reg     <= out_idx_next;
        end
    end

    // ports
    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = state_reg == ST_OUT;
    assign m_tlast  = out_last;
    assign m_tdata  = {4'b0000,
                       res_reg[out_idx_reg].result,
                       res_reg[out_idx_reg].buffer,
                       res_reg[out_idx_reg].len,
                       res_reg[out_idx_reg].data,
                       res_reg[out_idx_reg].addr,
                       res_reg[out_idx_reg].action,
                       acc_reg};

    // checks
    a_task_fill: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, task_count_reg} + {1'b0, task_staged_reg}) <= (TCW + 1)'(i2cjs_pkg::TASK_DEPTH))
        else $error("task ring overfilled");

    a_byte_fill: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, byte_count_reg} + {1'b0, byte_staged_reg}) < (BCW + 1)'(i2cjs_pkg::BYTE_DEPTH))
        else $error("byte ring overfilled");

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input taken while results pending");

    a_res_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res_n_reg <= 2'd2)
        else $error("result buffer count out of range");

    a_accept_to_work: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second transaction taken without processing");

endmodule
`default_nettype wire
